/* rtl/assert_macros.svh */
// assertion macros for the rtl files that check themselves
// no dependencies; the checks compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, held off while reset is high
`define SHA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sha check failed");
// clocked check that also holds during reset
`define SHA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("sha check failed");
`else
`define SHA_ASSERT(lbl, clk, rst, prop)
`define SHA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/sha_pkg.sv */
// shared types and constants of the sha-256 byte stream hasher
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sha_pkg;

   // input commands
   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam logic [7:0]  PAD_MARK     = 8'h80;
   localparam logic [63:0] BLOCK_BITS   = 64'd512;
   // length field starts at byte 56, i.e. word 14 of the block
   localparam logic [3:0]  LEN_WORD_POS = 4'd14;
   localparam logic [3:0]  LAST_WORD_POS = 4'd15;
   localparam logic [5:0]  LAST_ROUND   = 6'd63;
   localparam logic [2:0]  LAST_DIGEST  = 3'd7;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // one queue entry: a full message word, or the finish marker with the
   // partial word (bytes left-aligned) and how many bytes it holds
   typedef struct packed {
      logic        finish;
      logic [1:0]  nbytes;
      logic [31:0] word;
   } sha_qentry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sha_qstat_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_PAD    = 6'b000010,
      ST_LEN_LO = 6'b000100,
      ST_ROUND  = 6'b001000,
      ST_FOLD   = 6'b010000,
      ST_EMIT   = 6'b100000
   } sha_state_type;

   typedef enum logic [1:0] {
      BLK_DATA  = 2'd0,
      BLK_PAD   = 2'd1,
      BLK_FINAL = 2'd2
   } sha_block_type;

endpackage

/* rtl/sha_ifs.sv */
// valid/ready channel interfaces of the hasher: request beats and digest beats
// no dependencies
`timescale 1ns / 1ps

interface sha_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;
   modport source (output valid, command, data_byte, input ready);
   modport sink   (input valid, command, data_byte, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* rtl/sha_front.sv */
// front end: accepts request beats and packs bytes into big-endian words
// depends on sha_pkg and sha_req_if
`timescale 1ns / 1ps

module sha_front
   import sha_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   sha_req_if.sink        req_chan,
   input  sha_qstat_type  q_stat,
   output logic           q_push,
   output sha_qentry_type q_entry
);

   logic [31:0] partial_ff, partial_in;
   logic [1:0]  idx_ff, idx_in;
   logic        accept;

   assign req_chan.ready = !q_stat.full;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      partial_in = partial_ff;
      idx_in     = idx_ff;
      q_push     = 1'b0;
      q_entry    = '{finish: 1'b0, nbytes: 2'd0, word: 32'd0};
      if (accept) begin
         if (req_chan.command == CMD_FINISH) begin
            q_push     = 1'b1;
            q_entry    = '{finish: 1'b1, nbytes: idx_ff, word: partial_ff};
            partial_in = 32'd0;
            idx_in     = 2'd0;
         end else if (idx_ff == 2'd3) begin
            q_push     = 1'b1;
            q_entry    = '{finish: 1'b0, nbytes: 2'd0,
                           word: {partial_ff[31:8], req_chan.data_byte}};
            partial_in = 32'd0;
            idx_in     = 2'd0;
         end else begin
            // first byte lands in the top byte lane
            case (idx_ff)
               2'd0:    partial_in[31:24] = req_chan.data_byte;
               2'd1:    partial_in[23:16] = req_chan.data_byte;
               default: partial_in[15:8]  = req_chan.data_byte;
            endcase
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= 2'd0;
         partial_ff <= 32'd0;
      end else begin
         idx_ff     <= idx_in;
         partial_ff <= partial_in;
      end
   end

endmodule

/* rtl/sha_queue.sv */
// word queue between the front end and the compression engine
// depends on sha_pkg
`timescale 1ns / 1ps

module sha_queue
   import sha_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  sha_qentry_type push_entry,
   input  logic           pop,
   output sha_qentry_type head,
   output sha_qstat_type  stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sha_qentry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign head       = slots_ff[rd_ff];
   assign stat.full  = (fill_ff == CNT_W'(DEPTH));
   assign stat.empty = (fill_ff == '0);

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

/* rtl/sha_core.sv */
// back end: block window, padding, 64-round compression and digest output
// depends on sha_pkg and sha_rsp_if
`timescale 1ns / 1ps

module sha_core
   import sha_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  sha_qentry_type q_head,
   input  sha_qstat_type  q_stat,
   output logic           q_pop,
   sha_rsp_if.source      rsp_chan
);

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   sha_state_type state_ff, state_in;
   sha_block_type kind_ff, kind_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  emit_ff, emit_in;
   logic [63:0] bits_ff, bits_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [2:0]  rsp_index_ff, rsp_index_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        shift_en;
   logic [31:0] shift_word;
   logic [31:0] pad_word;
   logic [63:0] total_bits;
   logic [31:0] sched_new;
   logic [31:0] t1, t2, big0, big1, choose, major;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.digest_word = rsp_word_ff;
   assign rsp_chan.word_index  = rsp_index_ff;
   assign rsp_chan.last_word   = rsp_last_ff;

   // pad marker goes right after the buffered bytes of the partial word
   always_comb begin
      pad_word = q_head.word;
      case (q_head.nbytes)
         2'd0:    pad_word[31:24] = PAD_MARK;
         2'd1:    pad_word[23:16] = PAD_MARK;
         2'd2:    pad_word[15:8]  = PAD_MARK;
         default: pad_word[7:0]   = PAD_MARK;
      endcase
      total_bits = bits_ff + {55'd0, cnt_ff, q_head.nbytes, 3'b000};
   end

   // schedule word sixteen ahead of the current one
   assign sched_new = (rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10))
                    + w_ff[9]
                    + (rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3))
                    + w_ff[0];

   // one round
   always_comb begin
      big1   = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      choose = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1     = v_ff[7] + big1 + choose + ROUND_K[round_ff] + w_ff[0];
      big0   = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      major  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2     = big0 + major;
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cnt_in       = cnt_ff;
      round_in     = round_ff;
      emit_in      = emit_ff;
      bits_in      = bits_ff;
      len_in       = len_ff;
      h_in         = h_ff;
      v_in         = v_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      q_pop        = 1'b0;
      shift_en     = 1'b0;
      shift_word   = 32'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               shift_en = 1'b1;
               cnt_in   = cnt_ff + 4'd1;
               if (q_head.finish) begin
                  shift_word = pad_word;
                  len_in     = total_bits;
                  kind_in    = BLK_PAD;
                  state_in   = ST_PAD;
               end else begin
                  shift_word = q_head.word;
                  kind_in    = BLK_DATA;
               end
               if (cnt_ff == LAST_WORD_POS) begin
                  state_in = ST_ROUND;
                  round_in = 6'd0;
                  v_in     = h_ff;
               end
            end
         end
         ST_PAD: begin
            shift_en = 1'b1;
            cnt_in   = cnt_ff + 4'd1;
            if (cnt_ff == LEN_WORD_POS) begin
               shift_word = len_ff[63:32];
               state_in   = ST_LEN_LO;
            end else if (cnt_ff == LAST_WORD_POS) begin
               // length did not fit: compress this block and pad another
               kind_in  = BLK_PAD;
               state_in = ST_ROUND;
               round_in = 6'd0;
               v_in     = h_ff;
            end
         end
         ST_LEN_LO: begin
            shift_en   = 1'b1;
            shift_word = len_ff[31:0];
            cnt_in     = cnt_ff + 4'd1;
            kind_in    = BLK_FINAL;
            state_in   = ST_ROUND;
            round_in   = 6'd0;
            v_in       = h_ff;
         end
         ST_ROUND: begin
            shift_en   = 1'b1;
            shift_word = sched_new;
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
            end
            unique case (kind_ff)
               BLK_DATA: begin
                  bits_in  = bits_ff + BLOCK_BITS;
                  state_in = ST_IDLE;
               end
               BLK_PAD: begin
                  state_in = ST_PAD;
               end
               BLK_FINAL: begin
                  emit_in  = 3'd0;
                  state_in = ST_EMIT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = h_ff[0];
               rsp_index_in = emit_ff;
               rsp_last_in  = (emit_ff == LAST_DIGEST);
               for (int i = 0; i < 7; i++) begin
                  h_in[i] = h_ff[i + 1];
               end
               emit_in = emit_ff + 3'd1;
               if (emit_ff == LAST_DIGEST) begin
                  h_in     = INIT_H;
                  bits_in  = 64'd0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // message window: word 0 is the oldest
   always_comb begin
      w_in = w_ff;
      if (shift_en) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15] = shift_word;
      end
   end

   always_ff @(posedge clock) begin
      v_ff         <= v_in;
      w_ff         <= w_in;
      round_ff     <= round_in;
      emit_ff      <= emit_in;
      kind_ff      <= kind_in;
      len_ff       <= len_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 4'd0;
         bits_ff      <= 64'd0;
         h_ff         <= INIT_H;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bits_ff      <= bits_in;
         h_ff         <= h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/sha256_byte_stream_hasher.sv */
// sha-256 over a byte stream
// channels:
//   req_chan carries one beat per message byte (command absorb) or one
//   finish beat that closes the message; a beat is taken when valid and
//   ready are both high
//   rsp_chan returns the digest as eight 32-bit beats, word_index 0 first,
//   big-endian words, last_word set on the eighth
// timing:
//   bytes enter at one per cycle while req ready is high; every fourth byte
//   becomes a word in a queue of QUEUE_DEPTH words, so intake goes on while
//   a block is compressed; the engine loads the 16 words of a block, runs 64
//   rounds and a fold, and when bytes keep coming it is the engine that sets the rate
//   a finish beat adds padding and length words up to the end of the final block, one or
//   two compressions, then eight output beats at one per cycle while rsp ready is high
// reset: synchronous, active high; chaining words return to the initial
//   vector, bit count and buffered bytes go to zero, queue is emptied
// stall: a stalled receiver holds the current digest beat in the output
//   register; the engine waits there, the queue fills and then req ready
//   drops until space frees up
// depends on sha_pkg, sha_ifs, sha_front, sha_queue, sha_core and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha256_byte_stream_hasher
   import sha_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   sha_req_if.sink   req_chan,
   sha_rsp_if.source rsp_chan
);

   // front to queue
   logic           q_push;
   sha_qentry_type q_entry;
   // queue to back end
   logic           q_pop;
   sha_qentry_type q_head;
   sha_qstat_type  q_stat;
   // expected last_word flag of the beat on offer
   logic           last_expect;

   // packs bytes into words, marks the finish beat
   sha_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   // decouples byte intake from compression
   sha_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .stat       (q_stat)
   );

   // padding, rounds and digest beats
   sha_core u_core (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_stat   (q_stat),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

   assign last_expect = (rsp_chan.word_index == LAST_DIGEST);

   // queue must never overflow or underflow
   `SHA_ASSERT(a_no_push_full, clock, reset, q_push |-> !q_stat.full)
   `SHA_ASSERT(a_no_pop_empty, clock, reset, q_pop |-> !q_stat.empty)
   // last_word marks exactly the eighth digest beat
   `SHA_ASSERT(a_last_flag, clock, reset, rsp_chan.valid |-> rsp_chan.last_word == last_expect)

endmodule

/* sim/sha256_byte_stream_hasher_tb.sv */
// self-checking testbench for sha256_byte_stream_hasher: byte beats in, digest beats out
// depends on sha_pkg, sha_ifs and the dut; expected digests come from a sha-256 predictor in this file
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_tb
   import sha_pkg::*;
();

   localparam int unsigned RANDOM_ITEMS = 470;
   // last stretch of stimulus runs without idling on either side
   localparam int unsigned QUIET_ITEMS  = 60;
   // cycles with no beat on either channel before the run is abandoned
   localparam int unsigned STALL_LIMIT  = 5000;
   // after the last digest beat, watch for stray beats this long
   localparam int unsigned DRAIN_CYCLES = 300;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_beat_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_type;

   typedef enum int unsigned {
      FILL_RANDOM,
      FILL_ZEROS,
      FILL_ONES
   } fill_mode_type;

   logic clock;
   logic reset;

   sha_req_if req_if ();
   sha_rsp_if rsp_if ();

   sha256_byte_stream_hasher dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // round constants and initial vector of sha-256
   const logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };
   const logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // predictor state: chaining words, partial block, bytes in it, bits in full blocks
   logic [31:0] hash_state [8];
   logic [7:0]  msg_block [64];
   logic [5:0]  fill_count;
   logic [63:0] length_bits;

   req_beat_type    stimulus_q [$];
   digest_beat_type expected_digest_q [$];

   // handshake bookkeeping of the driver, the digest sink and the monitor
   bit          req_took;
   bit          req_busy;
   int unsigned req_gap;
   int unsigned rsp_stall;
   int unsigned idle_cycles;

   int unsigned error_count;
   int unsigned messages_hashed;
   int unsigned bytes_hashed;
   int unsigned two_block_finishes;
   int unsigned digest_beats_checked;

   // ---------------------------------------------------------------------------
   // sha-256 predictor
   // ---------------------------------------------------------------------------

   function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void restart_message();
      for (int i = 0; i < 8; i++) hash_state[i] = SHA_IV[i];
      fill_count  = '0;
      length_bits = '0;
   endfunction

   // one 64-round compression of msg_block into hash_state
   function automatic void compress_block();
      logic [31:0] w [64];
      logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      va = hash_state[0]; vb = hash_state[1]; vc = hash_state[2]; vd = hash_state[3];
      ve = hash_state[4]; vf = hash_state[5]; vg = hash_state[6]; vh = hash_state[7];
      for (int i = 0; i < 64; i++) begin
         t1 = vh + (ror32(ve, 6) ^ ror32(ve, 11) ^ ror32(ve, 25))
              + ((ve & vf) ^ (~ve & vg)) + SHA_K[i] + w[i];
         t2 = (ror32(va, 2) ^ ror32(va, 13) ^ ror32(va, 22))
              + ((va & vb) ^ (va & vc) ^ (vb & vc));
         vh = vg; vg = vf; vf = ve; ve = vd + t1;
         vd = vc; vc = vb; vb = va; va = t1 + t2;
      end
      hash_state[0] += va; hash_state[1] += vb; hash_state[2] += vc; hash_state[3] += vd;
      hash_state[4] += ve; hash_state[5] += vf; hash_state[6] += vg; hash_state[7] += vh;
   endfunction

   function automatic void predict_absorb(logic [7:0] data);
      msg_block[fill_count] = data;
      fill_count++;
      bytes_hashed++;
      if (fill_count == 0) begin
         compress_block();
         length_bits += 64'd512;
      end
   endfunction

   // pad, append the bit length, compress, and queue the eight digest beats
   function automatic void predict_finish();
      logic [63:0]     total_bits;
      digest_beat_type beat;
      total_bits = length_bits + {55'd0, fill_count, 3'b000};
      msg_block[fill_count] = 8'h80;
      for (int i = int'(fill_count) + 1; i < 64; i++) msg_block[i] = 8'h00;
      // no room left for the length field: spill into a second block
      if (fill_count >= 6'd56) begin
         compress_block();
         for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
         two_block_finishes++;
      end
      for (int i = 0; i < 8; i++) msg_block[56 + i] = total_bits[63 - 8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
         beat.word  = hash_state[i];
         beat.index = 3'(i);
         beat.last  = (i == 7);
         expected_digest_q.push_back(beat);
      end
      messages_hashed++;
      restart_message();
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------------

   task automatic push_absorb(logic [7:0] data);
      req_beat_type beat;
      beat.command   = CMD_ABSORB;
      beat.data_byte = data;
      stimulus_q.push_back(beat);
   endtask

   // data byte of a finish beat is don't-care, so it carries random bits
   task automatic push_finish();
      req_beat_type beat;
      beat.command   = CMD_FINISH;
      beat.data_byte = 8'($urandom);
      stimulus_q.push_back(beat);
   endtask

   task automatic queue_message(int unsigned nbytes, fill_mode_type fill);
      for (int unsigned i = 0; i < nbytes; i++) begin
         case (fill)
            FILL_ZEROS: push_absorb(8'h00);
            FILL_ONES:  push_absorb(8'hff);
            default:    push_absorb(8'($urandom));
         endcase
      end
      push_finish();
   endtask

   function automatic bit quiet_tail();
      return stimulus_q.size() < QUIET_ITEMS;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch: %s got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------------------
   // clock
   // ---------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // request driver: presents the head of stimulus_q at the falling edge and
   // drops it once the monitor has seen the beat taken
   // ---------------------------------------------------------------------------

   always @(negedge clock) begin
      if (!reset) begin
         if (req_took) begin
            stimulus_q.delete(0);
            req_busy = 1'b0;
            // idle burst between beats, never while a beat is on offer
            if (!quiet_tail() && $urandom_range(0, 7) == 0)
               req_gap = $urandom_range(1, 15);
         end
         if (req_busy) begin
            // beat still on offer, hold it
         end else if (req_gap != 0 || stimulus_q.size() == 0) begin
            if (req_gap != 0) req_gap--;
            req_if.valid     <= 1'b0;
            req_if.command   <= CMD_ABSORB;
            req_if.data_byte <= 8'h00;
         end else begin
            req_if.valid     <= 1'b1;
            req_if.command   <= stimulus_q[0].command;
            req_if.data_byte <= stimulus_q[0].data_byte;
            req_busy = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // digest sink: random stall bursts, steady ready near the end
   // ---------------------------------------------------------------------------

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else if (!quiet_tail() && $urandom_range(0, 9) == 0) begin
            rsp_stall = $urandom_range(0, 14);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: feeds taken request beats to the predictor, checks digest beats
   // against the oldest expectation, and counts cycles with no beat at all
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin : monitor
      digest_beat_type want;
      req_took = 1'b0;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            req_took = 1'b1;
            if (req_if.command == CMD_FINISH) predict_finish();
            else predict_absorb(req_if.data_byte);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_digest_q.size() == 0) begin
               report_mismatch("digest beat with none expected", rsp_if.digest_word, '0);
            end else begin
               want = expected_digest_q.pop_front();
               digest_beats_checked++;
               if (rsp_if.digest_word !== want.word)
                  report_mismatch("digest_word", rsp_if.digest_word, want.word);
               if (rsp_if.word_index !== want.index)
                  report_mismatch("word_index", 32'(rsp_if.word_index), 32'(want.index));
               if (rsp_if.last_word !== want.last)
                  report_mismatch("last_word", 32'(rsp_if.last_word), 32'(want.last));
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   // ---------------------------------------------------------------------------
   // run control: build stimulus, reset once, wait for the traffic to drain
   // ---------------------------------------------------------------------------

   initial begin : run_control
      int unsigned pick;
      int unsigned nbytes;
      int unsigned room;
      fill_mode_type fill;

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.command   = CMD_ABSORB;
      req_if.data_byte = 8'h00;
      rsp_if.ready     = 1'b0;
      restart_message();

      // directed: empty message, back to back finishes, "abc", byte extremes
      push_finish();
      push_finish();
      push_absorb(8'h61); push_absorb(8'h62); push_absorb(8'h63);
      push_finish();
      queue_message(1, FILL_ZEROS);
      queue_message(1, FILL_ONES);
      for (int i = 0; i < 8; i++) push_absorb(i[0] ? 8'haa : 8'h55);
      push_finish();

      // length field boundaries: last one-block pad, first and last two-block pads,
      // exactly one full block
      queue_message(55, FILL_RANDOM);
      queue_message(56, FILL_RANDOM);
      queue_message(63, FILL_RANDOM);
      queue_message(64, FILL_RANDOM);

      // random messages, mostly short so that finishes come often
      while (stimulus_q.size() < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         case (pick) inside
            [0:4]: nbytes = $urandom_range(0, 12);
            [5:6]: begin
               case ($urandom_range(0, 7))
                  0: nbytes = 55;
                  1: nbytes = 56;
                  2: nbytes = 57;
                  3: nbytes = 63;
                  4: nbytes = 64;
                  5: nbytes = 65;
                  6: nbytes = 119;
                  default: nbytes = 128;
               endcase
            end
            [7:8]: nbytes = $urandom_range(0, 140);
            default: nbytes = $urandom_range(141, 200);
         endcase
         // last message is trimmed so the run ends near the planned item count
         room = RANDOM_ITEMS - stimulus_q.size();
         if (nbytes >= room) nbytes = room - 1;
         case ($urandom_range(0, 9))
            0: fill = FILL_ZEROS;
            1: fill = FILL_ONES;
            default: fill = FILL_RANDOM;
         endcase
         queue_message(nbytes, fill);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while ((stimulus_q.size() != 0 || req_busy || expected_digest_q.size() != 0)
             && idle_cycles < STALL_LIMIT)
         @(posedge clock);
      if (idle_cycles < STALL_LIMIT)
         repeat (DRAIN_CYCLES) @(posedge clock);

      if (idle_cycles >= STALL_LIMIT) begin
         $display("[%0t] watchdog: no beat taken for %0d cycles", $realtime, idle_cycles);
         error_count++;
      end
      if (expected_digest_q.size() != 0)
         report_mismatch("digest beats still missing", '0, 32'(expected_digest_q.size()));

      $display("covered %0d messages, %0d bytes, %0d finishes needing a second pad block",
               messages_hashed, bytes_hashed, two_block_finishes);
      $display("checked %0d digest beats, %0d mismatches", digest_beats_checked, error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/sha_pkg.sv
rtl/sha_ifs.sv
rtl/sha_front.sv
rtl/sha_queue.sv
rtl/sha_core.sv
rtl/sha256_byte_stream_hasher.sv
sim/sha256_byte_stream_hasher_tb.sv
